>>> rtl/core/aac_pkg.sv
`default_nettype none

package aac_pkg;

    localparam int MAX_TAPS    = 8;
    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = SAMPLE_W + 7;
    localparam int TAP_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NTAP_W      = $clog2(MAX_TAPS + 1);
    localparam int LEN_W       = 4;
    localparam int THR_W       = 11;
    localparam int DZ_W        = 11;
    localparam int REST_W      = SAMPLE_W;
    localparam int OFS_W       = 11;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int VAL_W       = 12;
    localparam int DIFF_W      = 13;
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [LEN_W-1:0]    RESET_LENGTH    = LEN_W'(6);
    localparam logic [THR_W-1:0]    RESET_THRESHOLD = THR_W'(3);
    localparam logic [DZ_W-1:0]     RESET_DEADZONE  = DZ_W'(8);
    localparam logic [REST_W-1:0]   RESET_REST      = REST_W'(512);
    localparam logic [OFS_W-1:0]    RESET_OFFSET    = '0;
    localparam logic [SUM_W-1:0]    RESET_SUM       = SUM_W'(512 * 6);
    localparam logic [VAL_W-1:0]    RESET_LAST      = VAL_W'(512);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = '1;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_PRELOAD = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVERAGE_LENGTH   = 3'd0,
        REG_CHANGE_THRESHOLD = 3'd1,
        REG_DEADZONE_WIDTH   = 3'd2,
        REG_CENTERED_AXIS    = 3'd3,
        REG_REST_VALUE       = 3'd4,
        REG_OUTPUT_OFFSET    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_UPDATE,
        S_DIVIDE,
        S_SHAPE,
        S_COMPARE,
        S_OUTPUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/analog_axis_conditioner_core.sv
// Conditions raw converter samples of one joystick or trigger axis.
// Input channel: i_valid / o_stall with i_command and i_sample. A sample command
// runs the sample through a moving average, a deadzone snap, an offset and a
// change-threshold test; a preload command, when averaging is on, fills the sample
// history, the running sum and the last reported value. Every transfer in yields
// one transfer out on o_valid / i_stall carrying o_axis_value and o_changed.
// Items are handled one at a time. A sample with averaging goes through one history
// read, one sum update, one quotient bit per cycle from the serial divider, then
// deadzone, threshold and output steps. A sample without averaging goes straight
// to the deadzone step; a preload with averaging on writes each history entry in
// turn through the single memory write port. An item is taken only in the idle
// step, so the next one can follow once the sequencer is back there.
// The result sits in an output register, so the next item can be taken while the
// previous result waits. When the receiver stalls, a finished item waits in its
// last step until the output register frees up, and o_stall stays high.
// Reset (synchronous, active low) restores the register defaults, marks every
// history entry as holding the rest default 512, and sets the sum to 512 * 6.
// Configuration writes are taken in any cycle; indexes above five are ignored.
`default_nettype none

module analog_axis_conditioner_core
    import aac_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_command,
    input  wire logic [SAMPLE_W-1:0]         i_sample,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [VAL_W-1:0]          o_axis_value,
    output logic                             o_changed,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]            i_cfg_data
);

    // Configuration registers.
    logic [LEN_W-1:0]          r_cfg_len;
    logic [THR_W-1:0]          r_cfg_thr;
    logic [DZ_W-1:0]           r_cfg_dz;
    logic                      r_cfg_centered;
    logic [REST_W-1:0]         r_cfg_rest;
    logic [OFS_W-1:0]          r_cfg_ofs;

    // Sequencer and datapath state.
    t_state                    r_state;
    t_state                    n_state;
    logic [SAMPLE_W-1:0]       r_sample;
    logic [SUM_W-1:0]          r_sum;
    logic [TAP_W-1:0]          r_wpos;
    logic [TAP_W-1:0]          r_pos;
    logic [TAP_W-1:0]          r_fill_idx;
    logic signed [VAL_W-1:0]   r_last;
    logic signed [VAL_W-1:0]   r_value;
    logic                      r_report;
    logic [SUM_W-1:0]          r_quo;
    logic [NTAP_W-1:0]         r_rem;
    logic [DIV_CNT_W-1:0]      r_div_cnt;

    // History memory and its per-entry valid bits.
    logic [SAMPLE_W-1:0]       r_hist [MAX_TAPS];
    logic [MAX_TAPS-1:0]       r_hist_vld;
    logic [SAMPLE_W-1:0]       r_rd_data;
    logic                      r_rd_vld;

    // Output register.
    logic                      r_out_valid;
    logic signed [VAL_W-1:0]   r_out_value;
    logic                      r_out_changed;

    // Control decoded from the state.
    logic                      mem_we;
    logic [TAP_W-1:0]          mem_waddr;
    logic                      rd_en;
    logic                      out_load;
    logic                      accept;
    logic                      out_free;

    // Combinational datapath.
    logic [NTAP_W-1:0]         n_taps;
    logic [TAP_W-1:0]          start_pos;
    logic [SUM_W-1:0]          fill_sum;
    logic [SAMPLE_W-1:0]       old_sample;
    logic [SUM_W-1:0]          n_sum;
    logic [NTAP_W-1:0]         pos_inc;
    logic [TAP_W-1:0]          n_wpos;
    logic [NTAP_W:0]           div_trial;
    logic                      div_ge;
    logic [NTAP_W-1:0]         n_rem;
    logic [SAMPLE_W-1:0]       avg;
    logic signed [DIFF_W-1:0]  s_avg;
    logic signed [DIFF_W-1:0]  s_dz;
    logic signed [DIFF_W-1:0]  s_rest;
    logic signed [DIFF_W-1:0]  s_hi;
    logic signed [DIFF_W-1:0]  s_lo;
    logic                      in_dz;
    logic [SAMPLE_W-1:0]       v_dz;
    logic signed [VAL_W-1:0]   n_shaped;
    logic signed [DIFF_W-1:0]  s_diff;
    logic signed [DIFF_W-1:0]  s_thr;
    logic                      n_report;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Tap count saturates at the ring depth.
    assign n_taps = (r_cfg_len > LEN_W'(MAX_TAPS)) ? NTAP_W'(MAX_TAPS) : NTAP_W'(r_cfg_len);

    // A write position left beyond a shortened ring restarts at the first entry.
    assign start_pos = ({1'b0, r_wpos} >= n_taps) ? '0 : r_wpos;
    assign fill_sum  = SUM_W'(i_sample) * SUM_W'(n_taps);

    assign old_sample = r_rd_vld ? r_rd_data : RESET_REST;
    assign n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
    assign pos_inc    = NTAP_W'(r_pos) + NTAP_W'(1);
    assign n_wpos     = (pos_inc >= n_taps) ? '0 : TAP_W'(pos_inc);

    // Restoring division, one quotient bit per cycle; the dividend shifts out of
    // r_quo from the top while quotient bits shift in at the bottom.
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, n_taps};
    assign n_rem     = div_ge ? NTAP_W'(div_trial - {1'b0, n_taps}) : NTAP_W'(div_trial);

    assign avg = (r_quo > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : r_quo[SAMPLE_W-1:0];

    always_comb begin
        s_avg  = $signed({{(DIFF_W-SAMPLE_W){1'b0}}, avg});
        s_dz   = DIFF_W'($signed(r_cfg_dz));
        s_rest = $signed({{(DIFF_W-REST_W){1'b0}}, r_cfg_rest});
        if (r_cfg_centered) begin
            s_hi = s_rest + s_dz;
            s_lo = s_rest - s_dz;
        end else begin
            s_hi = s_dz;
            s_lo = '0;
        end
        // An all-ones width turns the deadzone off.
        in_dz    = (r_cfg_dz != '1) && (s_avg < s_hi) && (s_avg > s_lo);
        v_dz     = in_dz ? r_cfg_rest : avg;
        n_shaped = VAL_W'($signed({{(VAL_W-SAMPLE_W){1'b0}}, v_dz}))
                 + VAL_W'($signed(r_cfg_ofs));
    end

    always_comb begin
        s_diff   = DIFF_W'(r_value) - DIFF_W'(r_last);
        s_thr    = DIFF_W'($signed(r_cfg_thr));
        n_report = r_cfg_thr[THR_W-1] || (s_diff > s_thr) || (s_diff < -s_thr);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (t_cmd'(i_command) == CMD_PRELOAD) begin
                        n_state = (n_taps == '0) ? S_OUTPUT : S_FILL;
                    end else begin
                        n_state = (n_taps == '0) ? S_SHAPE : S_READ;
                    end
                end
            end
            S_FILL: begin
                if ({1'b0, r_fill_idx} == n_taps - NTAP_W'(1)) begin
                    n_state = S_OUTPUT;
                end
            end
            S_READ:    n_state = S_UPDATE;
            S_UPDATE:  n_state = S_DIVIDE;
            S_DIVIDE: begin
                if (r_div_cnt == '0) begin
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE:   n_state = S_COMPARE;
            S_COMPARE: n_state = S_OUTPUT;
            S_OUTPUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall   = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE:   o_stall = 1'b0;
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_fill_idx;
            end
            S_READ:   rd_en = 1'b1;
            S_UPDATE: mem_we = 1'b1;
            S_OUTPUT: out_load = out_free;
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len      <= RESET_LENGTH;
            r_cfg_thr      <= RESET_THRESHOLD;
            r_cfg_dz       <= RESET_DEADZONE;
            r_cfg_centered <= 1'b1;
            r_cfg_rest     <= RESET_REST;
            r_cfg_ofs      <= RESET_OFFSET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_AVERAGE_LENGTH:   r_cfg_len      <= i_cfg_data[LEN_W-1:0];
                REG_CHANGE_THRESHOLD: r_cfg_thr      <= i_cfg_data[THR_W-1:0];
                REG_DEADZONE_WIDTH:   r_cfg_dz       <= i_cfg_data[DZ_W-1:0];
                REG_CENTERED_AXIS:    r_cfg_centered <= i_cfg_data[0];
                REG_REST_VALUE:       r_cfg_rest     <= i_cfg_data[REST_W-1:0];
                REG_OUTPUT_OFFSET:    r_cfg_ofs      <= i_cfg_data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_waddr] <= r_sample;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[r_pos];
        end
    end

    // An entry never written reads as the rest default.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (mem_we) begin
                r_hist_vld[mem_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_hist_vld[r_pos];
            end
        end
    end

    // Persistent filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= RESET_SUM;
            r_wpos <= '0;
            r_last <= RESET_LAST;
        end else begin
            if (accept && t_cmd'(i_command) == CMD_PRELOAD && n_taps != '0) begin
                r_sum  <= fill_sum;
                r_last <= $signed({{(VAL_W-SAMPLE_W){1'b0}}, i_sample});
            end
            if (r_state == S_UPDATE) begin
                r_sum  <= n_sum;
                r_wpos <= n_wpos;
            end
            if (out_load && r_report) begin
                r_last <= r_value;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= i_sample;
            r_pos      <= start_pos;
            r_fill_idx <= '0;
            r_quo      <= SUM_W'(i_sample);
            r_value    <= $signed({{(VAL_W-SAMPLE_W){1'b0}}, i_sample});
            r_report   <= 1'b0;
        end
        if (r_state == S_FILL) begin
            r_fill_idx <= r_fill_idx + TAP_W'(1);
        end
        if (r_state == S_UPDATE) begin
            r_quo     <= n_sum;
            r_rem     <= '0;
            r_div_cnt <= DIV_CNT_W'(SUM_W - 1);
        end
        if (r_state == S_DIVIDE) begin
            r_quo     <= {r_quo[SUM_W-2:0], div_ge};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
        if (r_state == S_SHAPE) begin
            r_value <= n_shaped;
        end
        if (r_state == S_COMPARE) begin
            r_report <= n_report;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value   <= r_value;
            r_out_changed <= r_report;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_axis_value = r_out_value;
    assign o_changed    = r_out_changed;

    // A new result only appears after the sequencer's final step.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load == 1'b0 && !r_out_valid) |=> !r_out_valid)
        else $error("output became valid without a result being loaded");

    // The ring is addressed only inside the active tap count.
    a_read_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_pos} < n_taps))
        else $error("history read outside the active ring");

    a_wpos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> ({1'b0, r_wpos} < n_taps))
        else $error("write position left outside the active ring");

    // The partial remainder always stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |-> (r_rem < n_taps))
        else $error("divider remainder not below tap count");

    // Only an idle sequencer takes a new item.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while an item is in progress");

endmodule

`default_nettype wire

>>> tb/analog_axis_conditioner_core_test.sv
`timescale 1ns / 100ps

module analog_axis_conditioner_core_test;
    import aac_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int PLAN_ROWS    = 40;
    localparam int PHASE_BLOCKS = 10;
    localparam int BLOCK_ITEMS  = 57;
    localparam int SETTLE_WAIT  = 40;

    // Indexes past the last register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] axis_value;
        logic                    changed;
    } t_axis_result;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_data;
        t_cmd                 cmd;
        logic [SAMPLE_W-1:0]  smp;
        logic                 is_known;
        t_axis_result         known;
    } t_plan_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_command = 1'b0;
    logic [SAMPLE_W-1:0]        i_sample = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [VAL_W-1:0]    o_axis_value;
    logic                       o_changed;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    // Shadow copy of the registers and of the averaging state.
    logic [LEN_W-1:0]           len_reg = RESET_LENGTH;
    logic signed [THR_W-1:0]    thr_reg = RESET_THRESHOLD;
    logic signed [DZ_W-1:0]     dz_reg = RESET_DEADZONE;
    logic                       centered_reg = 1'b1;
    logic [REST_W-1:0]          rest_reg = RESET_REST;
    logic signed [OFS_W-1:0]    ofs_reg = RESET_OFFSET;
    logic [SAMPLE_W-1:0]        tap_ring [MAX_TAPS];
    logic [SUM_W-1:0]           tap_sum = RESET_SUM;
    int                         tap_slot = 0;
    int                         reported_value = 512;

    t_axis_result               pending_results [$];
    t_axis_result               head_result;
    t_plan_row                  directed_plan [PLAN_ROWS];
    int                         send_idle_pct = 17;
    int                         stall_pct = 73;
    int                         mismatch_count = 0;
    int                         cycle_count = 0;

    analog_axis_conditioner_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_axis_value (o_axis_value),
        .o_changed    (o_changed),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("analog_axis_conditioner_core_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_axis_result condition_item(t_cmd cmd, logic [SAMPLE_W-1:0] smp);
        t_axis_result res;
        int taps, slot, level, lo, hi, dz, rest, thr, diff;
        logic report;
        taps = (len_reg > MAX_TAPS) ? MAX_TAPS : int'(len_reg);
        if (cmd == CMD_PRELOAD) begin
            if (taps > 0) begin
                for (int k = 0; k < taps; k++) begin
                    tap_ring[k] = smp;
                end
                tap_sum = SUM_W'(int'(smp) * taps);
                reported_value = int'(smp);
            end
            res.axis_value = VAL_W'(int'(smp));
            res.changed = 1'b0;
            return res;
        end
        if (taps == 0) begin
            level = int'(smp);
        end else begin
            // A slot left over from a longer window restarts at the front.
            slot = (tap_slot >= taps) ? 0 : tap_slot;
            tap_sum = tap_sum - SUM_W'(tap_ring[slot]) + SUM_W'(smp);
            tap_ring[slot] = smp;
            slot = slot + 1;
            tap_slot = (slot >= taps) ? 0 : slot;
            level = int'(tap_sum) / taps;
            if (level > int'(SAMPLE_MAX)) begin
                level = int'(SAMPLE_MAX);
            end
        end
        dz = int'(dz_reg);
        rest = int'(rest_reg);
        if (dz != -1) begin
            hi = dz;
            lo = 0;
            if (centered_reg) begin
                hi = rest + dz;
                lo = rest - dz;
            end
            if (level < hi && level > lo) begin
                level = rest;
            end
        end
        level = level + int'(ofs_reg);
        thr = int'(thr_reg);
        if (thr < 0) begin
            report = 1'b1;
        end else begin
            diff = level - reported_value;
            report = (diff > thr) || (diff < -thr);
        end
        if (report) begin
            reported_value = level;
        end
        res.axis_value = VAL_W'(level);
        res.changed = report;
        return res;
    endfunction

    function automatic int pick_biased(int lo, int hi);
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 20) begin
            return lo;
        end
        if (roll < 40) begin
            return hi;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_index = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic t_plan_row item_row(t_cmd cmd, logic [SAMPLE_W-1:0] smp);
        t_plan_row row;
        row = '0;
        row.cmd = cmd;
        row.smp = smp;
        return row;
    endfunction

    function automatic t_plan_row known_row(t_cmd cmd, logic [SAMPLE_W-1:0] smp,
                                            int value, logic chg);
        t_plan_row row;
        row = item_row(cmd, smp);
        row.is_known = 1'b1;
        row.known.axis_value = VAL_W'(value);
        row.known.changed = chg;
        return row;
    endfunction

    // Called at the clock edge of the last transfer; returns at a later edge.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_AVERAGE_LENGTH:   len_reg = data[LEN_W-1:0];
            REG_CHANGE_THRESHOLD: thr_reg = data[THR_W-1:0];
            REG_DEADZONE_WIDTH:   dz_reg = data[DZ_W-1:0];
            REG_CENTERED_AXIS:    centered_reg = data[0];
            REG_REST_VALUE:       rest_reg = data[REST_W-1:0];
            REG_OUTPUT_OFFSET:    ofs_reg = data[OFS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(t_cmd cmd, logic [SAMPLE_W-1:0] smp, logic is_known,
                             t_axis_result known);
        t_axis_result predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_sample <= smp;
        do @(posedge i_clk); while (o_stall);
        predicted = condition_item(cmd, smp);
        pending_results.push_back(is_known ? known : predicted);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: axis_value %0d changed %0b",
                       o_axis_value, o_changed);
                mismatch_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_axis_value !== head_result.axis_value) begin
                    $error("axis_value: expected %0d, got %0d",
                           head_result.axis_value, o_axis_value);
                    mismatch_count++;
                end
                if (o_changed !== head_result.changed) begin
                    $error("changed: expected %0b, got %0b", head_result.changed, o_changed);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_cmd cmd;
        int roll, smp;
        logic drained;
        for (int k = 0; k < MAX_TAPS; k++) begin
            tap_ring[k] = RESET_REST;
        end
        directed_plan = '{
            known_row(CMD_SAMPLE, 10'd512, 512, 1'b0),
            known_row(CMD_PRELOAD, 10'd1023, 1023, 1'b0),
            known_row(CMD_SAMPLE, 10'd1023, 1023, 1'b0),
            known_row(CMD_PRELOAD, 10'd0, 0, 1'b0),
            known_row(CMD_SAMPLE, 10'd0, 0, 1'b0),
            item_row(CMD_SAMPLE, 10'd0),
            // With averaging off a preload leaves the history alone.
            cfg_row(REG_AVERAGE_LENGTH, 11'd0),
            known_row(CMD_PRELOAD, 10'd300, 300, 1'b0),
            item_row(CMD_SAMPLE, 10'd1023),
            item_row(CMD_SAMPLE, 10'd517),
            cfg_row(REG_CHANGE_THRESHOLD, 11'h7FF),
            item_row(CMD_SAMPLE, 10'd0),
            cfg_row(REG_DEADZONE_WIDTH, 11'h7FF),
            item_row(CMD_SAMPLE, 10'd515),
            // A negative width other than minus one has an empty deadzone.
            cfg_row(REG_DEADZONE_WIDTH, 11'h7FE),
            item_row(CMD_SAMPLE, 10'd512),
            cfg_row(REG_CENTERED_AXIS, 11'd0),
            cfg_row(REG_DEADZONE_WIDTH, 11'd100),
            cfg_row(REG_REST_VALUE, 11'd1023),
            item_row(CMD_SAMPLE, 10'd50),
            item_row(CMD_SAMPLE, 10'd100),
            item_row(CMD_SAMPLE, 10'd0),
            cfg_row(REG_OUTPUT_OFFSET, 11'h400),
            known_row(CMD_SAMPLE, 10'd0, -1024, 1'b1),
            cfg_row(REG_OUTPUT_OFFSET, 11'h3FF),
            known_row(CMD_SAMPLE, 10'd1023, 2046, 1'b1),
            cfg_row(REG_AVERAGE_LENGTH, 11'd15),
            cfg_row(REG_CHANGE_THRESHOLD, 11'd1023),
            known_row(CMD_PRELOAD, 10'd1023, 1023, 1'b0),
            // Shrinking the window leaves a stale sum and a slot past the end.
            cfg_row(REG_AVERAGE_LENGTH, 11'd1),
            item_row(CMD_SAMPLE, 10'd5),
            item_row(CMD_SAMPLE, 10'd5),
            cfg_row(REG_AVERAGE_LENGTH, 11'd8),
            item_row(CMD_SAMPLE, 10'd0),
            item_row(CMD_SAMPLE, 10'd1023),
            cfg_row(REG_SPARE_LO, 11'h7FF),
            cfg_row(REG_SPARE_HI, 11'd0),
            cfg_row(REG_CHANGE_THRESHOLD, 11'd0),
            item_row(CMD_SAMPLE, 10'd700),
            known_row(CMD_PRELOAD, 10'd512, 512, 1'b0)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drained = 1'b0;
        foreach (directed_plan[r]) begin
            if (directed_plan[r].is_cfg) begin
                if (!drained) begin
                    drain_results();
                end
                drained = 1'b1;
                write_reg(directed_plan[r].reg_index, directed_plan[r].reg_data);
            end else begin
                drained = 1'b0;
                send_item(directed_plan[r].cmd, directed_plan[r].smp,
                          directed_plan[r].is_known, directed_plan[r].known);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 73 : 0;
            stall_pct = (phase == 0) ? 73 : (phase == 1) ? 17 : 0;
            for (int blk = 0; blk < PHASE_BLOCKS; blk++) begin
                drain_results();
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_AVERAGE_LENGTH, ($urandom_range(0, 3) == 0) ?
                              CFG_W'(pick_biased(9, 15)) : CFG_W'(pick_biased(0, 8)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_CHANGE_THRESHOLD, $urandom_range(0, 1) ?
                              CFG_W'(pick_biased(-1, 8)) : CFG_W'(pick_biased(-1024, 1023)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_DEADZONE_WIDTH, $urandom_range(0, 1) ?
                              CFG_W'(pick_biased(-1, 40)) : CFG_W'(pick_biased(-1024, 1023)));
                end
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(REG_CENTERED_AXIS, CFG_W'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(REG_REST_VALUE, CFG_W'(pick_biased(0, 1023)));
                end
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(REG_OUTPUT_OFFSET, ($urandom_range(0, 4) < 2) ?
                              CFG_W'(0) : CFG_W'(pick_biased(-1024, 1023)));
                end
                if ($urandom_range(0, 7) == 0) begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                              CFG_W'($urandom));
                end
                for (int k = 0; k < BLOCK_ITEMS; k++) begin
                    // Most windows open with a preload so the sum starts consistent.
                    cmd = ((k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 9) == 0) ?
                          CMD_PRELOAD : CMD_SAMPLE;
                    roll = int'($urandom_range(0, 99));
                    if (roll < 10) begin
                        smp = 0;
                    end else if (roll < 20) begin
                        smp = int'(SAMPLE_MAX);
                    end else if (roll < 55) begin
                        smp = int'(rest_reg) + int'($urandom_range(0, 60)) - 30;
                        smp = (smp < 0) ? 0 : (smp > int'(SAMPLE_MAX)) ? int'(SAMPLE_MAX) : smp;
                    end else begin
                        smp = int'($urandom_range(0, int'(SAMPLE_MAX)));
                    end
                    send_item(cmd, SAMPLE_W'(smp), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("analog_axis_conditioner_core_test: clean");
        end else begin
            $display("analog_axis_conditioner_core_test: errors");
        end
        $finish;
    end

endmodule
